[sv/srle_pkg.sv]
// shared types and constants for the serial to rgb led slot encoder
package srle_pkg;

	// pixel geometry and slot numbering inside one pixel request
	localparam int BITS_PER_PIXEL = 24;
	localparam int SLOT_END       = BITS_PER_PIXEL + 1;
	localparam int SLOT_IDX_W     = $clog2(SLOT_END + 1);

	// serial command bytes
	localparam logic [7:0] CMD_START = 8'h07;
	localparam logic [7:0] CMD_DATA  = 8'h08;

	// duty value sent with a hold-high slot
	localparam logic [7:0] HOLD_HIGH_DUTY = 8'd20;

	// register reset values
	localparam logic [4:0] ZERO_DUTY_RST   = 5'd6;
	localparam logic [4:0] ONE_DUTY_RST    = 5'd14;
	localparam logic [7:0] RESET_TICKS_RST = 8'd5;
	localparam logic [7:0] MAX_CHUNK_RST   = 8'd254;

	// register indexes on the config port
	typedef enum logic [1:0] {
		REG_ZERO_DUTY   = 2'd0,
		REG_ONE_DUTY    = 2'd1,
		REG_RESET_TICKS = 2'd2,
		REG_MAX_CHUNK   = 2'd3
	} reg_idx_t;

	// parser phase
	typedef enum logic [1:0] {
		PH_CMD    = 2'd0,
		PH_CNT_LO = 2'd1,
		PH_CNT_HI = 2'd2,
		PH_PIX    = 2'd3
	} phase_t;

	// output slot kinds
	typedef enum logic [1:0] {
		SLOT_PWM  = 2'd0,
		SLOT_GAP  = 2'd1,
		SLOT_HOLD = 2'd2
	} slot_kind_t;

	// one job from the parser to the slot generator
	typedef struct packed {
		logic                      has_pixel;
		logic                      has_end;
		logic                      end_gap;
		logic [BITS_PER_PIXEL-1:0] pixel;
	} job_t;

endpackage

[sv/srle_front.sv]
// byte parser: tracks commands and chunks, turns complete pixels and empty chunks into jobs
module srle_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            max_chunk,
	output logic                  push_valid,
	output srle_pkg::job_t        push_job,
	input  logic                  q_full
);

	srle_pkg::phase_t phase_q, phase_d;
	logic [15:0] total_q, total_d;
	logic [15:0] done_q, done_d;
	logic [7:0]  chunk_left_q, chunk_left_d;
	logic [1:0]  bip_q, bip_d;
	logic [7:0]  held0_q, held1_q;
	logic        acc;
	logic [15:0] rem;
	logic [15:0] chunk;

	// a byte is taken whenever the job queue has room
	assign in_stall = q_full;
	assign acc      = in_valid && !q_full;

	// remaining leds and the size of a new chunk
	assign rem   = total_q - done_q;
	assign chunk = (rem < {8'd0, max_chunk}) ? rem : {8'd0, max_chunk};

	// next state and job generation
	always_comb begin
		phase_d      = phase_q;
		total_d      = total_q;
		done_d       = done_q;
		chunk_left_d = chunk_left_q;
		bip_d        = bip_q;
		push_valid   = 1'b0;
		push_job     = '0;
		if (acc) begin
			unique case (phase_q)
				srle_pkg::PH_CMD: begin
					if (rx_byte == srle_pkg::CMD_START) begin
						phase_d = srle_pkg::PH_CNT_LO;
					end else if (rx_byte == srle_pkg::CMD_DATA && done_q < total_q) begin
						done_d = done_q + chunk;
						if (chunk == 16'd0) begin
							// empty chunk: only the end slot, leds still remain
							push_valid       = 1'b1;
							push_job.has_end = 1'b1;
							push_job.end_gap = 1'b0;
						end else begin
							chunk_left_d = chunk[7:0];
							bip_d        = 2'd0;
							phase_d      = srle_pkg::PH_PIX;
						end
					end
				end
				srle_pkg::PH_CNT_LO: begin
					total_d = {8'd0, rx_byte};
					phase_d = srle_pkg::PH_CNT_HI;
				end
				srle_pkg::PH_CNT_HI: begin
					total_d = {rx_byte, total_q[7:0]};
					done_d  = 16'd0;
					phase_d = srle_pkg::PH_CMD;
				end
				srle_pkg::PH_PIX: begin
					if (bip_q != 2'd2) begin
						bip_d = bip_q + 2'd1;
					end else begin
						// third colour byte completes the pixel
						push_valid         = 1'b1;
						push_job.has_pixel = 1'b1;
						push_job.pixel     = {held1_q, held0_q, rx_byte};
						push_job.has_end   = (chunk_left_q == 8'd1);
						push_job.end_gap   = (done_q >= total_q);
						bip_d              = 2'd0;
						chunk_left_d       = chunk_left_q - 8'd1;
						if (chunk_left_q == 8'd1) begin
							phase_d = srle_pkg::PH_CMD;
						end
					end
				end
				default: begin
					phase_d = srle_pkg::PH_CMD;
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= srle_pkg::PH_CMD;
			total_q      <= 16'd0;
			done_q       <= 16'd0;
			chunk_left_q <= 8'd0;
			bip_q        <= 2'd0;
		end else begin
			phase_q      <= phase_d;
			total_q      <= total_d;
			done_q       <= done_d;
			chunk_left_q <= chunk_left_d;
			bip_q        <= bip_d;
		end
	end

	// first two colour bytes of the pixel
	always_ff @(posedge clk) begin
		if (acc && phase_q == srle_pkg::PH_PIX && bip_q == 2'd0) begin
			held0_q <= rx_byte;
		end
		if (acc && phase_q == srle_pkg::PH_PIX && bip_q == 2'd1) begin
			held1_q <= rx_byte;
		end
	end

endmodule

[sv/srle_queue.sv]
// small job queue between the parser and the slot generator
module srle_queue #(
	parameter int QDEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  srle_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output srle_pkg::job_t pop_job,
	output logic           empty
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

	srle_pkg::job_t mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL) else $error("queue count beyond depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full) else $error("push into full queue");
`endif

endmodule

[sv/srle_back.sv]
// slot generator: expands each job into low, bit and end slots
module srle_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  srle_pkg::job_t pop_job,
	output logic           pop,
	input  logic [4:0]     zero_duty,
	input  logic [4:0]     one_duty,
	input  logic [7:0]     reset_ticks,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     slot_kind,
	output logic [7:0]     duty,
	output logic           last
);

	localparam logic [srle_pkg::SLOT_IDX_W-1:0] IDX_END =
		srle_pkg::SLOT_IDX_W'(srle_pkg::SLOT_END);
	localparam logic [srle_pkg::SLOT_IDX_W-1:0] IDX_LAST_BIT =
		srle_pkg::SLOT_IDX_W'(srle_pkg::BITS_PER_PIXEL);

	srle_pkg::job_t job_q;
	logic [srle_pkg::BITS_PER_PIXEL-1:0] shift_q;
	logic [srle_pkg::SLOT_IDX_W-1:0]     idx_q;
	logic                                busy_q;
	logic                                out_valid_q;
	srle_pkg::slot_kind_t                kind_q, kind_d;
	logic [7:0]                          duty_q, duty_d;
	logic                                last_q;
	logic                                adv, emit, last_slot, load;

	// output register frees when empty or taken
	assign adv       = !out_valid_q || !out_stall;
	assign emit      = busy_q && adv;
	assign last_slot = (idx_q == IDX_END) || (idx_q == IDX_LAST_BIT && !job_q.has_end);
	assign load      = !q_empty && (!busy_q || (emit && last_slot));
	assign pop       = load;

	// slot contents for the current index
	always_comb begin
		priority if (idx_q == '0) begin
			kind_d = srle_pkg::SLOT_PWM;
			duty_d = 8'd0;
		end else if (idx_q == IDX_END) begin
			kind_d = job_q.end_gap ? srle_pkg::SLOT_GAP : srle_pkg::SLOT_HOLD;
			duty_d = job_q.end_gap ? reset_ticks : srle_pkg::HOLD_HIGH_DUTY;
		end else begin
			kind_d = srle_pkg::SLOT_PWM;
			duty_d = shift_q[srle_pkg::BITS_PER_PIXEL-1] ? {3'd0, one_duty}
				: {3'd0, zero_duty};
		end
	end

	// job sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= pop_job.has_pixel ? '0 : IDX_END;
			end else if (emit && last_slot) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= (idx_q == IDX_LAST_BIT) ? IDX_END : idx_q + 1'b1;
			end
		end
	end

	// job payload and bit shifter
	always_ff @(posedge clk) begin
		if (load) begin
			job_q   <= pop_job;
			shift_q <= pop_job.pixel;
		end else if (emit && idx_q != '0) begin
			shift_q <= {shift_q[srle_pkg::BITS_PER_PIXEL-2:0], 1'b0};
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= kind_d;
			duty_q <= duty_d;
			last_q <= last_slot;
		end
	end

	assign out_valid = out_valid_q;
	assign slot_kind = kind_q;
	assign duty      = duty_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= IDX_END) else $error("slot index out of range");
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != srle_pkg::SLOT_PWM |-> last_q)
		else $error("end slot not marked last");
`endif

endmodule

[sv/serial_to_rgb_led_slot_encoder.sv]
// Serial to RGB LED slot encoder. Serial bytes enter on rx_byte; command 0x07 plus a
// little-endian 16-bit count sets the number of LEDs, command 0x08 opens a chunk of
// up to max_chunk pixels of three colour bytes. Each complete pixel yields 25 slots
// (one low slot, then 24 PWM bit slots in the order second byte, first byte, third
// byte, MSB first), and the last pixel of a chunk one more end slot: a reset gap when
// all LEDs are done, else a hold-high slot. The parser takes one byte per cycle while
// its job queue (QDEPTH entries) has room; the slot generator issues one slot per cycle
// while out_stall is low and starts the next queued pixel right after the final slot of
// the previous one. last marks the final slot of each job.
// Registers (byte address 4*i): zero_duty, one_duty, reset_ticks, max_chunk.
module serial_to_rgb_led_slot_encoder #(
	parameter int QDEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  slot_kind,
	output logic [7:0]  duty,
	output logic        last
);

	logic [4:0] zero_duty_q;
	logic [4:0] one_duty_q;
	logic [7:0] reset_ticks_q;
	logic [7:0] max_chunk_q;
	logic       wr_en;
	srle_pkg::reg_idx_t reg_sel;

	logic           push_valid;
	srle_pkg::job_t push_job;
	logic           q_full, q_empty, pop;
	srle_pkg::job_t pop_job;

	// config register port
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = srle_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_duty_q   <= srle_pkg::ZERO_DUTY_RST;
			one_duty_q    <= srle_pkg::ONE_DUTY_RST;
			reset_ticks_q <= srle_pkg::RESET_TICKS_RST;
			max_chunk_q   <= srle_pkg::MAX_CHUNK_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				srle_pkg::REG_ZERO_DUTY:   zero_duty_q   <= pwdata[4:0];
				srle_pkg::REG_ONE_DUTY:    one_duty_q    <= pwdata[4:0];
				srle_pkg::REG_RESET_TICKS: reset_ticks_q <= pwdata[7:0];
				srle_pkg::REG_MAX_CHUNK:   max_chunk_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_sel)
			srle_pkg::REG_ZERO_DUTY:   prdata = {27'd0, zero_duty_q};
			srle_pkg::REG_ONE_DUTY:    prdata = {27'd0, one_duty_q};
			srle_pkg::REG_RESET_TICKS: prdata = {24'd0, reset_ticks_q};
			srle_pkg::REG_MAX_CHUNK:   prdata = {24'd0, max_chunk_q};
			default:                   prdata = 32'd0;
		endcase
	end

	// byte parser
	srle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.max_chunk  (max_chunk_q),
		.push_valid (push_valid),
		.push_job   (push_job),
		.q_full     (q_full)
	);

	// job queue
	srle_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	// slot generator
	srle_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.pop_job     (pop_job),
		.pop         (pop),
		.zero_duty   (zero_duty_q),
		.one_duty    (one_duty_q),
		.reset_ticks (reset_ticks_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.slot_kind   (slot_kind),
		.duty        (duty),
		.last        (last)
	);

endmodule
